/* hw/rtl/kvs_pkg.sv */
// ----------------------------------------------------------------------------
// kvs_pkg
// Shared types and codes of the keyframe vector sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package kvs_pkg;

	localparam int VAL_W = 32;
	localparam int FRAC_W = 16;
	// The interpolation weight runs from 0 to exactly 1.0 in Q1.16.
	localparam int T_W = FRAC_W + 1;

	// One value per component, index 0 is x, 1 is y, 2 is z.
	typedef logic [2:0][VAL_W-1:0] vec_t;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_INTERP = 2'd0,
		ST_AFTER  = 2'd1,
		ST_BEFORE = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIRST,
		S_WALK,
		S_DIV,
		S_V0,
		S_V1,
		S_V2,
		S_LERP,
		S_KEYRD,
		S_KEYCAP,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

/* hw/rtl/kvs_divider.sv */
// ----------------------------------------------------------------------------
// kvs_divider
// Restoring divider, one quotient bit per cycle, for the span weight.
// ----------------------------------------------------------------------------
`default_nettype none

module kvs_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [kvs_pkg::VAL_W-1:0] dividend,
	input  logic [kvs_pkg::VAL_W-1:0] divisor,
	output logic                      done,
	output logic [kvs_pkg::T_W-1:0]   quotient
);
	import kvs_pkg::*;

	localparam int CNT_W = $clog2(T_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] rem_q;
	logic [VAL_W-1:0] div_q;
	logic [T_W-1:0]   quo_q;

	logic [VAL_W:0]   shifted;
	logic [VAL_W:0]   trial;
	logic             take;
	logic [VAL_W-1:0] rem_next;

	// The dividend is the offset shifted up by the fraction width. Since the
	// offset never exceeds the divisor, the first step compares it unshifted.
	always_comb begin
		shifted  = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
		trial    = shifted - {1'b0, div_q};
		take     = (shifted >= {1'b0, div_q});
		rem_next = take ? trial[VAL_W-1:0] : shifted[VAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(T_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[T_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/kvs_lerp.sv */
// ----------------------------------------------------------------------------
// kvs_lerp
// Blends two vectors by a Q1.16 weight, one component at a time through a
// single multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module kvs_lerp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [kvs_pkg::T_W-1:0] weight,
	input  kvs_pkg::vec_t           va,
	input  kvs_pkg::vec_t           vb,
	output logic                    done,
	output kvs_pkg::vec_t           result
);
	import kvs_pkg::*;

	localparam int PROD_W = VAL_W + 1 + T_W + 1;

	logic        busy_q;
	logic        done_q;
	logic [1:0]  comp_q;
	logic [1:0]  phase_q;
	vec_t        a_q;
	vec_t        b_q;
	vec_t        res_q;
	logic [T_W-1:0] t_q;

	logic signed [VAL_W:0]    diff_s1;
	logic signed [PROD_W-1:0] prod_s2;

	// Each component goes through subtract, multiply and add in turn.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			comp_q  <= '0;
			phase_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				comp_q  <= '0;
				phase_q <= '0;
			end else if (busy_q) begin
				if (phase_q == 2'd2) begin
					phase_q <= '0;
					comp_q  <= comp_q + 2'd1;
					if (comp_q == 2'd2) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					phase_q <= phase_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= va;
			b_q <= vb;
			t_q <= weight;
		end else if (busy_q) begin
			case (phase_q)
				2'd0: diff_s1 <= $signed({b_q[comp_q][VAL_W-1], b_q[comp_q]})
						- $signed({a_q[comp_q][VAL_W-1], a_q[comp_q]});
				2'd1: prod_s2 <= PROD_W'(diff_s1) * PROD_W'($signed({1'b0, t_q}));
				2'd2: res_q[comp_q] <= a_q[comp_q] + prod_s2[FRAC_W +: VAL_W];
				default: ;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

/* hw/rtl/keyframe_vector_sampler.sv */
// ----------------------------------------------------------------------------
// keyframe_vector_sampler
// Keyframe table with linear interpolation of a three-component vector.
// ----------------------------------------------------------------------------
// Usage: an input item with command write stores key_time and key_x/y/z at
// key_index and gives no result. A sample item takes query_time
// and gives one result item: out_x/y/z and status. cfg_wen/cfg_wdata set
// key_count, the number of valid keys, and may only be written while idle.
// A sample reads the time memory one key per cycle while it walks the
// spans; when the query lands in a span it then waits on the serial
// divider, three vector memory reads and the shared multiplier.
// Empty-table queries skip the walk and go straight to the result.
// The time memory read port sets the walk rate.
// in_stall is high while a sample is at work. A result waits in the output
// register while out_stall is high; the next item may be accepted meanwhile
// and a second result then waits inside until the register frees.
// Reset clears key_count and the output valid; the key memories are not
// cleared and hold undefined data until written.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_vector_sampler #(
	parameter int MAX_KEYS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  key_index,
	input  logic [31:0] key_time,
	input  logic [31:0] key_x,
	input  logic [31:0] key_y,
	input  logic [31:0] key_z,
	input  logic [31:0] query_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic [1:0]  status,
	input  logic        cfg_wen,
	input  logic [8:0]  cfg_wdata
);
	import kvs_pkg::*;

	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);

	state_t state_q, state_d;

	logic [8:0]    key_count_q;
	logic [CW-1:0] n_keys;
	logic          out_valid_q;

	logic [VAL_W-1:0] time_mem [MAX_KEYS];
	vec_t             vec_mem  [MAX_KEYS];
	logic [VAL_W-1:0] time_rdata_q;
	vec_t             vec_rdata_q;
	logic [AW-1:0]    time_raddr;
	logic [AW-1:0]    vec_raddr;
	logic             mem_we;

	logic [VAL_W-1:0] q_q;
	logic [VAL_W-1:0] prev_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    base_q;
	status_t          status_q;
	vec_t             v0_q;
	vec_t             res_q;
	vec_t             out_vec_q;
	status_t          out_status_q;

	logic             accept;
	logic             hit;
	logic             last;
	logic [VAL_W-1:0] span;
	logic             div_start;
	logic             div_done;
	logic [T_W-1:0]   weight;
	logic             lerp_start;
	logic             lerp_done;
	vec_t             lerp_res;
	logic             out_free;

	assign n_keys = (32'(key_count_q) > 32'(MAX_KEYS)) ? CW'(MAX_KEYS) : CW'(key_count_q);
	assign accept = in_valid && !in_stall;
	assign mem_we = accept && (command == CMD_WRITE) && (32'(key_index) < 32'(MAX_KEYS));

	assign hit  = (prev_q <= q_q) && (q_q <= time_rdata_q);
	assign span = time_rdata_q - prev_q;
	assign last = (CW'(idx_q) + CW'(1)) == n_keys;
	assign out_free = !out_valid_q || !out_stall;

	// Key memories: one write port for the write command, one read port each.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			time_mem[AW'(key_index)] <= key_time;
		end
		time_rdata_q <= time_mem[time_raddr];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vec_mem[AW'(key_index)] <= {key_z, key_y, key_x};
		end
		vec_rdata_q <= vec_mem[vec_raddr];
	end

	kvs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (q_q - prev_q),
		.divisor  (span),
		.done     (div_done),
		.quotient (weight)
	);

	kvs_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_start),
		.weight (weight),
		.va     (v0_q),
		.vb     (vec_rdata_q),
		.done   (lerp_done),
		.result (lerp_res)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && command == CMD_SAMPLE) begin
					state_d = (n_keys == '0) ? S_DONE : S_FIRST;
				end
			end
			S_FIRST: begin
				if (q_q < time_rdata_q || n_keys == CW'(1)) begin
					state_d = S_KEYRD;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (hit) begin
					state_d = (span == '0) ? S_KEYRD : S_DIV;
				end else if (last) begin
					state_d = S_KEYRD;
				end
			end
			S_DIV:    if (div_done) state_d = S_V0;
			S_V0:     state_d = S_V1;
			S_V1:     state_d = S_V2;
			S_V2:     state_d = S_LERP;
			S_LERP:   if (lerp_done) state_d = S_DONE;
			S_KEYRD:  state_d = S_KEYCAP;
			S_KEYCAP: state_d = S_DONE;
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = (state_q != S_IDLE);
		div_start  = 1'b0;
		lerp_start = 1'b0;
		time_raddr = idx_q + AW'(1);
		vec_raddr  = base_q;
		unique case (state_q)
			S_IDLE:  time_raddr = '0;
			S_FIRST: time_raddr = AW'(1);
			S_WALK:  div_start = hit && (span != '0);
			S_V1:    vec_raddr = base_q + AW'(1);
			S_V2:    lerp_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			key_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				key_count_q <= cfg_wdata;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				q_q      <= query_time;
				res_q    <= '0;
				status_q <= ST_EMPTY;
			end
			S_FIRST: begin
				base_q <= '0;
				prev_q <= time_rdata_q;
				idx_q  <= AW'(1);
				status_q <= (q_q < time_rdata_q) ? ST_BEFORE : ST_AFTER;
			end
			S_WALK: begin
				if (hit) begin
					base_q   <= idx_q - AW'(1);
					status_q <= ST_INTERP;
				end else if (last) begin
					base_q   <= idx_q;
					status_q <= ST_AFTER;
				end else begin
					prev_q <= time_rdata_q;
					idx_q  <= idx_q + AW'(1);
				end
			end
			S_V1:     v0_q <= vec_rdata_q;
			S_LERP:   if (lerp_done) res_q <= lerp_res;
			S_KEYCAP: res_q <= vec_rdata_q;
			S_DONE: begin
				if (out_free) begin
					out_vec_q    <= res_q;
					out_status_q <= status_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_vec_q[0];
	assign out_y     = out_vec_q[1];
	assign out_z     = out_vec_q[2];
	assign status    = out_status_q;

`ifndef SYNTHESIS
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == S_IDLE)
		else $error("key memory written while a sample is at work");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the division wait");
	a_lerp_done: assert property (@(posedge clk) disable iff (!arst_n)
		lerp_done |-> state_q == S_LERP)
		else $error("blend finished outside the blend wait");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (out_x == '0 && out_y == '0 && out_z == '0))
		else $error("empty-table result carries a nonzero vector");
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		lerp_start |-> weight <= T_W'(1 << FRAC_W))
		else $error("interpolation weight above one");
`endif

endmodule

`default_nettype wire
